// ===== sv/ckht_pkg.sv =====
// Package: shared types and constants of the configuration key hash table.
`default_nettype none

package ckht_pkg;

    localparam int BUCKETS  = 256;
    localparam int BUCKET_W = 8;
    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 10;
    localparam int FILL_W   = 4;
    localparam int REQ_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_slot;

    function automatic logic [BUCKET_W-1:0] fold_key(input logic [KEY_W-1:0] key);
        return key[15:8] ^ key[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/config_key_hash_table_top.sv =====
// Top level: chained hash table of configuration keys with one bucket-row memory.
//
//  Port group      Dir  Handshake                 Payload
//  --------------  ---  ------------------------  ------------------------------------------
//  request         in   start & !busy             i_req_type, i_entry_key, i_entry_handle
//  result          out  o_valid, one-cycle pulse  o_found, o_found_handle, o_status
//
//  In a request, the bucket row is read from the row memory in the
//  accept cycle, then compared, updated and written back in the next one. busy
//  is high for that cycle and the result word is strobed the cycle after,
//  overlapping the next accept. Clear drops every bucket's valid bit in one
//  cycle, so there is no clearing pass after reset. The receiver cannot stall.
`default_nettype none

module config_key_hash_table_top
    import ckht_pkg::*;
#(
    parameter int CHAIN_DEPTH  = 8,
    parameter int HANDLE_COUNT = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [REQ_W-1:0]    i_req_type,
    input  wire logic [KEY_W-1:0]    i_entry_key,
    input  wire logic [HANDLE_W-1:0] i_entry_handle,
    output logic                     o_valid,
    output logic                     o_found,
    output logic [HANDLE_W-1:0]      o_found_handle,
    output logic                     o_status
);

    typedef struct packed {
        logic [FILL_W-1:0]            fill;
        t_slot [CHAIN_DEPTH-1:0]      slot;
    } t_row;

    t_row mem [BUCKETS];

    logic                 accept;
    logic                 r_busy;
    logic [REQ_W-1:0]     r_req;
    logic [KEY_W-1:0]     r_key;
    logic [HANDLE_W-1:0]  r_handle;
    logic                 r_handle_ok;
    logic [BUCKET_W-1:0]  r_bucket;
    logic                 r_row_valid;
    t_row                 r_rd_row;
    logic [BUCKETS-1:0]   r_bkt_valid;

    logic                 r_out_valid;
    logic                 r_found;
    logic [HANDLE_W-1:0]  r_found_handle;
    logic                 r_status;

    logic [FILL_W-1:0]    fill;
    logic                 hit;
    logic [HANDLE_W-1:0]  hit_handle;
    logic                 full;
    logic                 wr_en;
    logic                 clr_en;
    t_row                 n_row;
    logic                 n_found;
    logic [HANDLE_W-1:0]  n_found_handle;
    logic                 n_status;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req       <= i_req_type;
            r_key       <= i_entry_key;
            r_handle    <= i_entry_handle;
            r_handle_ok <= {1'b0, i_entry_handle} < (HANDLE_W + 1)'(HANDLE_COUNT);
            r_bucket    <= fold_key(i_entry_key);
            r_row_valid <= r_bkt_valid[fold_key(i_entry_key)];
            r_rd_row    <= mem[fold_key(i_entry_key)];
        end
    end

    always_comb begin
        fill = r_row_valid ? r_rd_row.fill : '0;
        if (fill > FILL_W'(CHAIN_DEPTH)) begin
            fill = FILL_W'(CHAIN_DEPTH);
        end
        full = fill >= FILL_W'(CHAIN_DEPTH);
    end

    always_comb begin
        hit        = 1'b0;
        hit_handle = '0;
        for (int i = CHAIN_DEPTH - 1; i >= 0; i--) begin
            if (FILL_W'(i) < fill && r_rd_row.slot[i].key == r_key) begin
                hit        = 1'b1;
                hit_handle = r_rd_row.slot[i].handle;
            end
        end
    end

    always_comb begin
        n_row      = r_rd_row;
        n_row.fill = fill + FILL_W'(1);
        for (int i = 0; i < CHAIN_DEPTH; i++) begin
            if (FILL_W'(i) == fill) begin
                n_row.slot[i].key    = r_key;
                n_row.slot[i].handle = r_handle;
            end
        end
    end

    always_comb begin
        wr_en          = 1'b0;
        clr_en         = 1'b0;
        n_found        = 1'b0;
        n_found_handle = '0;
        n_status       = 1'b0;
        unique case (r_req)
            REQ_CLEAR: begin
                clr_en = r_busy;
            end
            REQ_INSERT: begin
                wr_en    = r_busy && r_handle_ok && !full;
                n_status = r_handle_ok && full;
            end
            REQ_LOOKUP: begin
                n_found        = hit;
                n_found_handle = hit_handle;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_bucket] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bkt_valid <= '0;
        end else if (clr_en) begin
            r_bkt_valid <= '0;
        end else if (wr_en) begin
            r_bkt_valid[r_bucket] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_found        <= 1'b0;
            r_found_handle <= '0;
            r_status       <= 1'b0;
        end else if (r_busy) begin
            r_out_valid    <= 1'b1;
            r_found        <= n_found;
            r_found_handle <= n_found_handle;
            r_status       <= n_status;
        end else begin
            r_out_valid    <= 1'b0;
            r_found        <= 1'b0;
            r_found_handle <= '0;
            r_status       <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_found_handle = r_found_handle;
    assign o_status       = r_status;

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held longer than one cycle");

    a_word_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_out_valid)
        else $error("result word missing after request");

    a_word_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !r_busy)
        else $error("result word without request");

    a_quiet_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> (!r_found && !r_status && r_found_handle == '0))
        else $error("result fields active without strobe");

    a_no_found_and_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_found && r_status))
        else $error("found and overflow in the same word");

endmodule

`default_nettype wire

// ===== sim/tb_config_key_hash_table_top.sv =====
// Testbench: random and directed clear, insert, lookup and unused-code traffic against the key hash table.
`timescale 1ns / 100ps

module tb_config_key_hash_table_top
    import ckht_pkg::*;
();

    localparam int CHAIN_DEPTH  = 8;
    localparam int HANDLE_COUNT = 1024;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        logic [REQ_W-1:0]    req;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_req_word;

    typedef struct {
        logic                found;
        logic [HANDLE_W-1:0] handle;
        logic                status;
    } t_reply;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [REQ_W-1:0]    i_req_type = '0;
    logic [KEY_W-1:0]    i_entry_key = '0;
    logic [HANDLE_W-1:0] i_entry_handle = '0;
    logic                o_valid;
    logic                o_found;
    logic [HANDLE_W-1:0] o_found_handle;
    logic                o_status;

    t_req_word pending_words[$];
    t_reply    expected_replies[$];
    logic [KEY_W-1:0] known_keys[$];

    logic [FILL_W-1:0]   bucket_fill [BUCKETS] = '{default: '0};
    logic [KEY_W-1:0]    slot_key    [BUCKETS][CHAIN_DEPTH];
    logic [HANDLE_W-1:0] slot_handle [BUCKETS][CHAIN_DEPTH];

    int        idle_pct = 0;
    int        fail_count = 0;
    int        quiet_cycles = 0;
    logic      word_taken = 1'b0;
    t_req_word next_word;
    t_req_word seen_word;
    t_reply    due;

    config_key_hash_table_top #(
        .CHAIN_DEPTH (CHAIN_DEPTH),
        .HANDLE_COUNT(HANDLE_COUNT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_entry_key   (i_entry_key),
        .i_entry_handle(i_entry_handle),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_found_handle(o_found_handle),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_reply hash_table_step(input t_req_word w);
        t_reply           r;
        logic [BUCKET_W-1:0] b;
        int               fill;
        r.found  = 1'b0;
        r.handle = '0;
        r.status = 1'b0;
        b    = w.key[15:8] ^ w.key[7:0];
        fill = int'(bucket_fill[b]);
        if (fill > CHAIN_DEPTH) fill = CHAIN_DEPTH;
        case (w.req)
            REQ_CLEAR: begin
                for (int i = 0; i < BUCKETS; i++) bucket_fill[i] = '0;
            end
            REQ_INSERT: begin
                if (w.handle < HANDLE_COUNT) begin
                    if (fill >= CHAIN_DEPTH) begin
                        r.status = 1'b1;
                    end else begin
                        slot_key[b][fill]    = w.key;
                        slot_handle[b][fill] = w.handle;
                        bucket_fill[b]       = FILL_W'(fill + 1);
                    end
                end
            end
            REQ_LOOKUP: begin
                // scan from the tail so the earliest match wins
                for (int i = fill - 1; i >= 0; i--) begin
                    if (slot_key[b][i] == w.key) begin
                        r.found  = 1'b1;
                        r.handle = slot_handle[b][i];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_word(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                             input logic [HANDLE_W-1:0] handle);
        t_req_word w;
        w.req    = req;
        w.key    = key;
        w.handle = handle;
        pending_words.push_back(w);
    endtask

    // mostly keys folding into buckets 0 to 3 so chains fill up and overflow
    function automatic logic [KEY_W-1:0] hot_key();
        logic [7:0] hi;
        logic [7:0] bucket;
        hi     = 8'($urandom_range(0, 255));
        bucket = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 25) return KEY_W'($urandom);
        return {hi, hi ^ bucket};
    endfunction

    task automatic queue_random_words(input int count);
        int roll;
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 999);
            key  = hot_key();
            if (roll < 10) begin
                push_word(REQ_CLEAR, KEY_W'($urandom), HANDLE_W'($urandom));
                known_keys.delete();
            end else if (roll < 40) begin
                push_word(REQ_UNUSED, KEY_W'($urandom), HANDLE_W'($urandom));
            end else if (roll < 500) begin
                push_word(REQ_INSERT, key, HANDLE_W'($urandom_range(0, HANDLE_COUNT - 1)));
                known_keys.push_back(key);
            end else begin
                if (known_keys.size() > 0 && $urandom_range(0, 99) < 60)
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                push_word(REQ_LOOKUP, key, HANDLE_W'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || start || expected_replies.size() > 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || word_taken) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_word = pending_words.pop_front();
                start          <= 1'b1;
                i_req_type     <= next_word.req;
                i_entry_key    <= next_word.key;
                i_entry_handle <= next_word.handle;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= start && !busy;
            if (o_valid) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected word found=%0b handle=%0d status=%0b",
                             $time, o_found, o_found_handle, o_status);
                    fail_count++;
                end else begin
                    due = expected_replies.pop_front();
                    if (o_found !== due.found) begin
                        $display("%0t: found expected %0b actual %0b", $time, due.found, o_found);
                        fail_count++;
                    end
                    if (o_found_handle !== due.handle) begin
                        $display("%0t: found_handle expected %0d actual %0d",
                                 $time, due.handle, o_found_handle);
                        fail_count++;
                    end
                    if (o_status !== due.status) begin
                        $display("%0t: status expected %0b actual %0b",
                                 $time, due.status, o_status);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                seen_word.req    = i_req_type;
                seen_word.key    = i_entry_key;
                seen_word.handle = i_entry_handle;
                expected_replies.push_back(hash_table_step(seen_word));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int idle_by_phase[4];
        idle_by_phase = '{0, 47, 0, 19};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_word(REQ_LOOKUP, 16'h0000, 10'd0);
        push_word(REQ_INSERT, 16'h0000, 10'd0);
        push_word(REQ_INSERT, 16'hFFFF, 10'd1023);
        push_word(REQ_LOOKUP, 16'h0000, 10'd0);
        push_word(REQ_LOOKUP, 16'hFFFF, 10'd0);
        push_word(REQ_INSERT, 16'h0000, 10'd5);
        push_word(REQ_LOOKUP, 16'h0000, 10'h3FF);
        for (int i = 1; i <= 6; i++)
            push_word(REQ_INSERT, {i[7:0], i[7:0]}, 10'(100 + i));
        push_word(REQ_LOOKUP, 16'h0505, 10'd0);
        push_word(REQ_LOOKUP, 16'h0606, 10'd0);
        push_word(REQ_LOOKUP, 16'h1234, 10'd0);
        push_word(REQ_UNUSED, 16'hFFFF, 10'h3FF);
        push_word(REQ_CLEAR, 16'hFFFF, 10'h3FF);
        push_word(REQ_LOOKUP, 16'h0000, 10'd0);
        push_word(REQ_INSERT, 16'h8001, 10'd512);
        push_word(REQ_LOOKUP, 16'h8001, 10'd0);
        push_word(REQ_CLEAR, 16'h0000, 10'd0);

        for (int p = 0; p < 4; p++) begin
            idle_pct = idle_by_phase[p];
            queue_random_words(482);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
